[src/sfc_pkg.sv]
package sfc_pkg;

   // Memory geometry; the array must hold at least 64 KiB and at most 16 MiB
   localparam int unsigned MEMORY_BYTES = 1048576;
   localparam int unsigned ADDR_W       = $clog2(MEMORY_BYTES);
   localparam int unsigned ECNT_W       = ADDR_W + 1;
   localparam int unsigned ASM_W        = 24;
   localparam int unsigned MIN_MEM_LOG  = 16;
   localparam int unsigned MOD_TOP      = ASM_W - MIN_MEM_LOG - 1;
   localparam int unsigned MOD_K_W      = $clog2(MOD_TOP + 1);
   localparam int unsigned MOD_W        = ASM_W + MOD_TOP + 1;
   localparam int unsigned CNT_W        = 3;
   localparam int unsigned QDEPTH       = 2;
   localparam int unsigned QPTR_W       = $clog2(QDEPTH);
   localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

   // Opcodes
   localparam logic [7:0] OP_PROGRAM      = 8'h02;
   localparam logic [7:0] OP_READ         = 8'h03;
   localparam logic [7:0] OP_FAST_READ    = 8'h0B;
   localparam logic [7:0] OP_WREN         = 8'h06;
   localparam logic [7:0] OP_WRDI         = 8'h04;
   localparam logic [7:0] OP_ERASE_4K     = 8'h20;
   localparam logic [7:0] OP_ERASE_32K    = 8'h52;
   localparam logic [7:0] OP_ERASE_64K    = 8'hD8;
   localparam logic [7:0] OP_CHIP_ERASE_A = 8'h60;
   localparam logic [7:0] OP_CHIP_ERASE_B = 8'hC7;
   localparam logic [7:0] OP_RDSR1        = 8'h05;
   localparam logic [7:0] OP_RDSR2        = 8'h35;
   localparam logic [7:0] OP_JEDEC_ID     = 8'h9F;
   localparam logic [7:0] OP_DEVICE_ID    = 8'h90;

   // Identification and status bytes
   localparam logic [7:0] ID_MANUF   = 8'h1F;
   localparam logic [7:0] ID_TYPE    = 8'h85;
   localparam logic [7:0] ID_CAP     = 8'h01;
   localparam logic [7:0] ID_DEVICE  = 8'h13;
   localparam logic [7:0] SR_WEL     = 8'h02;
   localparam logic [7:0] BYTE_NONE  = 8'h00;
   localparam logic [7:0] BYTE_ERASED = 8'hFF;

   // Event kind on the request channel
   localparam logic EVT_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_UNSUPPORTED,
      ERR_NO_WEL
   } err_type;

   typedef enum logic [1:0] {
      ITEM_RELEASE,
      ITEM_OPCODE,
      ITEM_DATA
   } item_kind_type;

   typedef struct packed {
      item_kind_type    kind;
      logic [7:0]       data;
      logic [CNT_W-1:0] index;
   } item_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_ERASE
   } back_state_type;

endpackage

[src/spi_flash_command_slave.sv]
// Flow: each transaction passes through a two-entry queue to the back end, whose result
// register holds its reply; the third address byte first runs the restoring address reduction
// (then an array read for a read), and later read bytes wait for the registered array read.
// The queue takes new transactions while the back end is busy, until it fills; an erase
// holds the back end while it clears the window byte by byte. Reset: synchronous; clears
// control state and then sweeps the array to 0xFF, during which no transaction is accepted.
module spi_flash_command_slave
   import sfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_event_kind,
   input  logic [7:0] req_mosi_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_miso_next,
   output logic [1:0] rsp_error_code
);

   back_status_type status;
   logic            push_valid;
   logic            push_ready;
   item_type        push_data;
   logic            q_valid;
   logic            q_ready;
   item_type        q_data;

   sfc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_kind (req_event_kind),
      .req_mosi_byte  (req_mosi_byte),
      .status         (status),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   sfc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   sfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_data         (q_data),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_miso_next  (rsp_miso_next),
      .rsp_error_code (rsp_error_code)
   );

   // Back end only pops a queued transaction
   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_ready |-> q_valid)
      else $error("back end popped an empty queue");

   // No transaction accepted during the clearing pass
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_ready)
      else $error("transaction accepted while clearing");

   // Error results never drive data
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != 2'(ERR_NONE)) |-> (rsp_miso_next == BYTE_NONE))
      else $error("error result carries data");

   // Only defined error codes appear
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == 2'(ERR_NONE) || rsp_error_code == 2'(ERR_UNSUPPORTED)
                     || rsp_error_code == 2'(ERR_NO_WEL)))
      else $error("undefined error code");

endmodule

[src/sfc_front.sv]
module sfc_front
   import sfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_event_kind,
   input  logic [7:0]      req_mosi_byte,
   input  back_status_type status,
   output logic            push_valid,
   input  logic            push_ready,
   output item_type        push_data
);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             accept;

   // Hold off new transactions while the array is being cleared after reset
   assign req_ready  = push_ready && !status.clearing;
   assign push_valid = req_valid && !status.clearing;
   assign accept     = req_valid && req_ready;

   // Classify the transaction by its place in the frame
   always_comb begin
      push_data.data  = req_mosi_byte;
      push_data.index = cnt_ff;
      if (req_event_kind == EVT_RELEASE) begin
         push_data.kind = ITEM_RELEASE;
      end else if (cnt_ff == '0) begin
         push_data.kind = ITEM_OPCODE;
      end else begin
         push_data.kind = ITEM_DATA;
      end
   end

   // Count bytes in the frame, saturating; drop back to zero on release
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_event_kind == EVT_RELEASE) begin
            cnt_in = '0;
         end else if (cnt_ff != '1) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[src/sfc_fifo.sv]
module sfc_fifo
   import sfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   item_type          entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Store pushed transactions
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[src/sfc_back.sv]
module sfc_back
   import sfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_ready,
   input  item_type        q_data,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_miso_next,
   output logic [1:0]      rsp_error_code
);

   localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEMORY_BYTES - 1);
   localparam logic [ECNT_W-1:0] MEM_E    = ECNT_W'(MEMORY_BYTES);
   localparam logic [MOD_W-1:0]  MEM_M    = MOD_W'(MEMORY_BYTES);
   localparam logic [ASM_W:0]    MEM_A    = (ASM_W + 1)'(MEMORY_BYTES);

   // Array storage
   logic [7:0]        flash_mem [MEMORY_BYTES];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [ADDR_W-1:0] rd_addr;

   // Control and frame state
   back_state_type     state_ff, state_in;
   logic               wel_ff, wel_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [ASM_W-1:0]   addr_ff, addr_in;
   logic               ign_ff, ign_in;
   logic               idph_ff, idph_in;
   logic [MOD_K_W-1:0] k_ff, k_in;
   logic [ECNT_W-1:0]  er_addr_ff, er_addr_in;
   logic [ECNT_W-1:0]  er_end_ff, er_end_in;
   logic               clear_ff;

   // Result register
   logic               out_valid_ff;
   logic [7:0]         out_miso_ff;
   err_type            out_err_ff;
   logic               emit;
   logic [7:0]         emit_miso;
   err_type            emit_err;

   // Decode helpers
   logic              take;
   logic              fixed_reply;
   logic              blk_erase;
   logic              chip_erase;
   logic              rel_erase;
   logic              data_mod;
   logic              data_rd;
   logic [ADDR_W-1:0] addr_inc;
   logic [ASM_W-1:0]  page_next;
   logic [7:0]        wel_status;
   logic [MOD_W-1:0]  mod_sub;
   logic [ECNT_W-1:0] er_size;
   logic [ECNT_W-1:0] er_base;
   logic [ECNT_W-1:0] er_top;
   err_type           op_err;

   function automatic err_type opcode_check(input logic [7:0] op, input logic wel);
      err_type e;
      case (op)
         OP_READ, OP_FAST_READ, OP_WREN, OP_WRDI,
         OP_RDSR1, OP_RDSR2, OP_JEDEC_ID, OP_DEVICE_ID: e = ERR_NONE;
         OP_PROGRAM, OP_ERASE_4K, OP_ERASE_32K, OP_ERASE_64K,
         OP_CHIP_ERASE_A, OP_CHIP_ERASE_B: e = wel ? ERR_NONE : ERR_NO_WEL;
         default: e = ERR_UNSUPPORTED;
      endcase
      return e;
   endfunction

   assign take = (state_ff == ST_IDLE) && q_valid && (!out_valid_ff || rsp_ready);
   assign q_ready = take;

   assign fixed_reply = (cmd_ff == OP_RDSR1) || (cmd_ff == OP_JEDEC_ID) ||
                        (cmd_ff == OP_DEVICE_ID);
   assign blk_erase   = (cmd_ff == OP_ERASE_4K) || (cmd_ff == OP_ERASE_32K) ||
                        (cmd_ff == OP_ERASE_64K);
   assign chip_erase  = (cmd_ff == OP_CHIP_ERASE_A) || (cmd_ff == OP_CHIP_ERASE_B);

   assign rel_erase = (q_data.kind == ITEM_RELEASE) && (q_data.index != '0) && !ign_ff &&
                      ((blk_erase && q_data.index >= CNT_W'(4)) || chip_erase);
   assign data_mod  = (q_data.kind == ITEM_DATA) && !ign_ff && !fixed_reply &&
                      (q_data.index == CNT_W'(3));
   assign data_rd   = (q_data.kind == ITEM_DATA) && !ign_ff && !fixed_reply &&
                      (q_data.index >= CNT_W'(4)) &&
                      ((cmd_ff == OP_READ) || (cmd_ff == OP_FAST_READ));

   // Address arithmetic: sequential wrap at end of array, page wrap for program
   assign addr_inc   = (addr_ff[ADDR_W-1:0] == MEM_LAST) ? '0 : addr_ff[ADDR_W-1:0] + 1'b1;
   assign page_next  = {addr_ff[ASM_W-1:8], addr_ff[7:0] + 8'd1};
   assign wel_status = wel_ff ? SR_WEL : BYTE_NONE;
   assign mod_sub    = MEM_M << k_ff;
   assign op_err     = opcode_check(q_data.data, wel_ff);

   // Aligned erase window, clipped at the end of the array
   always_comb begin
      case (cmd_ff)
         OP_ERASE_4K:  er_size = ECNT_W'(4096);
         OP_ERASE_32K: er_size = ECNT_W'(32768);
         default:      er_size = ECNT_W'(65536);
      endcase
   end
   assign er_base = ECNT_W'(addr_ff[ADDR_W-1:0]) & ~(er_size - 1'b1);
   assign er_top  = er_base + er_size;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (rel_erase) begin
                  state_in = ST_ERASE;
               end else if (data_mod) begin
                  state_in = ST_MOD;
               end else if (data_rd) begin
                  state_in = ST_RD_WAIT;
               end
            end
         end
         ST_MOD: begin
            if (k_ff == '0) begin
               state_in = (cmd_ff == OP_READ) ? ST_RD_ISSUE : ST_IDLE;
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_WAIT;
         ST_RD_WAIT:  state_in = ST_IDLE;
         ST_ERASE: begin
            if (er_addr_ff == er_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result
   always_comb begin
      wel_in     = wel_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      ign_in     = ign_ff;
      idph_in    = idph_ff;
      k_in       = k_ff;
      er_addr_in = er_addr_ff;
      er_end_in  = er_end_ff;
      mem_we     = 1'b0;
      mem_wa     = addr_ff[ADDR_W-1:0];
      mem_wd     = q_data.data;
      rd_addr    = addr_ff[ADDR_W-1:0];
      emit       = 1'b0;
      emit_miso  = BYTE_NONE;
      emit_err   = ERR_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (q_data.kind)
                  ITEM_RELEASE: begin
                     // Apply the frame's effect at chip-select release
                     emit   = 1'b1;
                     ign_in = 1'b0;
                     if (q_data.index != '0 && !ign_ff) begin
                        case (cmd_ff)
                           OP_WREN: wel_in = 1'b1;
                           OP_WRDI: wel_in = 1'b0;
                           OP_PROGRAM: begin
                              if (q_data.index >= CNT_W'(5)) begin
                                 wel_in = 1'b0;
                              end
                           end
                           OP_ERASE_4K, OP_ERASE_32K, OP_ERASE_64K: begin
                              if (q_data.index >= CNT_W'(4)) begin
                                 wel_in     = 1'b0;
                                 er_addr_in = er_base;
                                 er_end_in  = (er_top > MEM_E) ? MEM_E : er_top;
                              end
                           end
                           OP_CHIP_ERASE_A, OP_CHIP_ERASE_B: begin
                              wel_in     = 1'b0;
                              er_addr_in = '0;
                              er_end_in  = MEM_E;
                           end
                           default: ;
                        endcase
                     end
                  end
                  ITEM_OPCODE: begin
                     emit     = 1'b1;
                     emit_err = op_err;
                     cmd_in   = q_data.data;
                     addr_in  = '0;
                     idph_in  = 1'b0;
                     if (op_err != ERR_NONE) begin
                        ign_in = 1'b1;
                     end else if (q_data.data == OP_RDSR1) begin
                        emit_miso = wel_status;
                     end else if (q_data.data == OP_JEDEC_ID) begin
                        emit_miso = ID_MANUF;
                     end
                  end
                  ITEM_DATA: begin
                     if (ign_ff) begin
                        emit = 1'b1;
                     end else if (fixed_reply) begin
                        emit = 1'b1;
                        case (cmd_ff)
                           OP_RDSR1: emit_miso = wel_status;
                           OP_JEDEC_ID: begin
                              if (q_data.index == CNT_W'(1)) begin
                                 emit_miso = ID_TYPE;
                              end else if (q_data.index == CNT_W'(2)) begin
                                 emit_miso = ID_CAP;
                              end
                           end
                           default: begin
                              if (q_data.index >= CNT_W'(3)) begin
                                 emit_miso = idph_ff ? ID_DEVICE : ID_MANUF;
                                 idph_in   = ~idph_ff;
                              end
                           end
                        endcase
                     end else if (q_data.index <= CNT_W'(3)) begin
                        // Shift in an address byte; reduce after the third
                        addr_in = {addr_ff[ASM_W-9:0], q_data.data};
                        if (q_data.index == CNT_W'(3)) begin
                           k_in = MOD_K_W'(MOD_TOP);
                        end else begin
                           emit = 1'b1;
                        end
                     end else begin
                        case (cmd_ff)
                           OP_READ: begin
                              addr_in = ASM_W'(addr_inc);
                              rd_addr = addr_inc;
                           end
                           OP_FAST_READ: begin
                              if (q_data.index >= CNT_W'(5)) begin
                                 addr_in = ASM_W'(addr_inc);
                                 rd_addr = addr_inc;
                              end
                           end
                           OP_PROGRAM: begin
                              emit    = 1'b1;
                              mem_we  = ({1'b0, addr_ff} < MEM_A);
                              addr_in = page_next;
                           end
                           default: emit = 1'b1;
                        endcase
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_MOD: begin
            // One restoring step of the address reduction
            if (MOD_W'(addr_ff) >= mod_sub) begin
               addr_in = addr_ff - mod_sub[ASM_W-1:0];
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0 && cmd_ff != OP_READ) begin
               emit = 1'b1;
            end
         end
         ST_RD_ISSUE: ;
         ST_RD_WAIT: begin
            emit      = 1'b1;
            emit_miso = rd_data_ff;
         end
         ST_ERASE: begin
            if (er_addr_ff != er_end_ff) begin
               mem_we     = 1'b1;
               mem_wa     = er_addr_ff[ADDR_W-1:0];
               mem_wd     = BYTE_ERASED;
               er_addr_in = er_addr_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Array write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flash_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= flash_mem[rd_addr];
   end

   // Control registers; reset starts a clearing pass over the whole array
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ERASE;
         wel_ff       <= 1'b0;
         cmd_ff       <= '0;
         addr_ff      <= '0;
         ign_ff       <= 1'b0;
         idph_ff      <= 1'b0;
         k_ff         <= '0;
         er_addr_ff   <= '0;
         er_end_ff    <= MEM_E;
         clear_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wel_ff     <= wel_in;
         cmd_ff     <= cmd_in;
         addr_ff    <= addr_in;
         ign_ff     <= ign_in;
         idph_ff    <= idph_in;
         k_ff       <= k_in;
         er_addr_ff <= er_addr_in;
         er_end_ff  <= er_end_in;
         if (state_ff == ST_ERASE && er_addr_ff == er_end_ff) begin
            clear_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_miso_ff <= emit_miso;
         out_err_ff  <= emit_err;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_miso_next    = out_miso_ff;
   assign rsp_error_code   = out_err_ff;
   assign status.clearing  = clear_ff;

endmodule

[tb/sv/spi_flash_command_slave_tb.sv]
module spi_flash_command_slave_tb;
   import sfc_pkg::*;

   localparam logic        EVT_XFER       = ~EVT_RELEASE;
   localparam int unsigned RANDOM_ITEMS   = 400;
   localparam int unsigned WATCHDOG_LIMIT = 4 * MEMORY_BYTES + 4096;
   localparam int unsigned SETTLE_CYCLES  = 32;

   typedef struct packed {
      logic [7:0] miso;
      err_type    err;
   } reply_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       pinned;
      reply_type  reply;
   } plan_row_type;

   // Opening sequence; pinned rows carry their reply, the rest use the predictor
   localparam plan_row_type OPENING [27] = '{
      '{EVT_RELEASE, 8'h00,            1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_RDSR1,         1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_PROGRAM,       1'b1, '{BYTE_NONE, ERR_NO_WEL}},
      '{EVT_XFER,    8'h00,            1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'hFF,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    8'hFF,            1'b1, '{BYTE_NONE, ERR_UNSUPPORTED}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_WREN,          1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_PROGRAM,       1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_RDSR1,         1'b1, '{SR_WEL,    ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_ERASE_4K,      1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    8'hFF,            1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_CHIP_ERASE_A,  1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_CHIP_ERASE_B,  1'b1, '{BYTE_NONE, ERR_NO_WEL}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_RDSR2,         1'b1, '{BYTE_NONE, ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}},
      '{EVT_XFER,    OP_JEDEC_ID,      1'b1, '{ID_MANUF,  ERR_NONE}},
      '{EVT_XFER,    8'h00,            1'b1, '{ID_TYPE,   ERR_NONE}},
      '{EVT_XFER,    8'hFF,            1'b1, '{ID_CAP,    ERR_NONE}},
      '{EVT_RELEASE, 8'h00,            1'b0, '{BYTE_NONE, ERR_NONE}}
   };

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_event_kind = 1'b0;
   logic [7:0] req_mosi_byte  = 8'h00;
   logic       rsp_ready      = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire  [7:0] rsp_miso_next;
   wire  [1:0] rsp_error_code;

   // Shadow of the device: array image, latch and frame decode
   logic [7:0]  image [MEMORY_BYTES];
   logic        latch_set  = 1'b0;
   logic [7:0]  frame_op   = 8'h00;
   logic [2:0]  frame_len  = 3'd0;
   logic [23:0] cur_addr   = 24'd0;
   logic        frame_dead = 1'b0;
   logic        id_odd     = 1'b0;

   reply_type   pending_replies [$];
   int unsigned useful_items = 0;
   int unsigned quiet_cycles = 0;
   logic        no_gaps      = 1'b0;
   logic        failed       = 1'b0;

   spi_flash_command_slave dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_kind (req_event_kind),
      .req_mosi_byte  (req_mosi_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_miso_next  (rsp_miso_next),
      .rsp_error_code (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the shadow by one transaction and return the reply it gives
   function automatic reply_type next_reply(input logic kind, input logic [7:0] b);
      reply_type   r;
      logic [2:0]  n;
      int unsigned span;
      int unsigned base;
      int unsigned stop;
      r = '{BYTE_NONE, ERR_NONE};
      span = 0;
      base = 0;
      if (kind == EVT_RELEASE) begin
         if (frame_len != 0 && !frame_dead) begin
            case (frame_op)
               OP_WREN:      latch_set = 1'b1;
               OP_WRDI:      latch_set = 1'b0;
               OP_PROGRAM:   if (frame_len >= 5) latch_set = 1'b0;
               OP_ERASE_4K:  if (frame_len >= 4) span = 4096;
               OP_ERASE_32K: if (frame_len >= 4) span = 32768;
               OP_ERASE_64K: if (frame_len >= 4) span = 65536;
               OP_CHIP_ERASE_A, OP_CHIP_ERASE_B: span = MEMORY_BYTES;
               default: ;
            endcase
         end
         // Clear the aligned block, clipped at the end of the array
         if (span != 0) begin
            if (frame_op != OP_CHIP_ERASE_A && frame_op != OP_CHIP_ERASE_B)
               base = (cur_addr / span) * span;
            stop = base + span;
            if (stop > MEMORY_BYTES) stop = MEMORY_BYTES;
            for (int unsigned i = base; i < stop; i++) image[i] = BYTE_ERASED;
            latch_set = 1'b0;
         end
         frame_len  = 3'd0;
         frame_dead = 1'b0;
         return r;
      end

      n = frame_len;
      if (frame_len < 3'd7) frame_len = frame_len + 3'd1;

      // Opcode byte: decode, flag and answer the first slot
      if (n == 3'd0) begin
         frame_op = b;
         cur_addr = 24'd0;
         id_odd   = 1'b0;
         case (b)
            OP_READ, OP_FAST_READ, OP_WREN, OP_WRDI,
            OP_RDSR1, OP_RDSR2, OP_JEDEC_ID, OP_DEVICE_ID:
               r.err = ERR_NONE;
            OP_PROGRAM, OP_ERASE_4K, OP_ERASE_32K, OP_ERASE_64K,
            OP_CHIP_ERASE_A, OP_CHIP_ERASE_B:
               r.err = latch_set ? ERR_NONE : ERR_NO_WEL;
            default:
               r.err = ERR_UNSUPPORTED;
         endcase
         if (r.err != ERR_NONE) frame_dead = 1'b1;
         else if (b == OP_RDSR1) r.miso = latch_set ? SR_WEL : BYTE_NONE;
         else if (b == OP_JEDEC_ID) r.miso = ID_MANUF;
         return r;
      end
      if (frame_dead) return r;

      case (frame_op)
         OP_RDSR1: begin
            r.miso = latch_set ? SR_WEL : BYTE_NONE;
            return r;
         end
         OP_JEDEC_ID: begin
            if (n == 3'd1) r.miso = ID_TYPE;
            else if (n == 3'd2) r.miso = ID_CAP;
            return r;
         end
         OP_DEVICE_ID: begin
            if (n >= 3'd3) begin
               r.miso = id_odd ? ID_DEVICE : ID_MANUF;
               id_odd = ~id_odd;
            end
            return r;
         end
         default: ;
      endcase

      // Shift in the address; reduce it once the third byte lands
      if (n <= 3'd3) begin
         cur_addr = {cur_addr[15:0], b};
         if (n == 3'd3) begin
            cur_addr = 24'(cur_addr % MEMORY_BYTES);
            if (frame_op == OP_READ) r.miso = image[cur_addr];
         end
         return r;
      end

      case (frame_op)
         OP_READ: begin
            cur_addr = 24'((cur_addr + 1) % MEMORY_BYTES);
            r.miso   = image[cur_addr];
         end
         OP_FAST_READ: begin
            if (n >= 3'd5) cur_addr = 24'((cur_addr + 1) % MEMORY_BYTES);
            r.miso = image[cur_addr];
         end
         OP_PROGRAM: begin
            if (cur_addr < MEMORY_BYTES) image[cur_addr] = b;
            cur_addr[7:0] = cur_addr[7:0] + 8'd1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one transaction, hold it until taken, then record its reply
   task automatic send_item(input logic kind, input logic [7:0] data,
                            input logic pinned, input reply_type pinned_reply);
      reply_type predicted;
      while (!no_gaps && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_event_kind <= kind;
      req_mosi_byte  <= data;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (kind == EVT_RELEASE || !frame_dead) useful_items++;
      predicted = next_reply(kind, data);
      pending_replies.push_back(pinned ? pinned_reply : predicted);
   endtask

   // Drop valid and hold off until every reply is back
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // Address with a random top nibble, mostly near hot spots so reads see writes
   function automatic logic [23:0] pick_address();
      int unsigned offs;
      int unsigned wraps;
      case ($urandom_range(0, 3))
         0:       offs = 32'h100 + $urandom_range(0, 511);
         1:       offs = MEMORY_BYTES / 2 - 8 + $urandom_range(0, 15);
         2:       offs = MEMORY_BYTES - 16 + $urandom_range(0, 15);
         default: offs = $urandom_range(0, MEMORY_BYTES - 1);
      endcase
      wraps = $urandom_range(0, (32'd1 << 24) / MEMORY_BYTES - 1);
      return 24'(wraps * MEMORY_BYTES + offs);
   endfunction

   // One frame: mostly well-formed commands with random content, some noise
   task automatic send_random_frame();
      logic [7:0]  op;
      logic [7:0]  body [$];
      logic [23:0] a;
      logic        needs_latch;
      logic        has_addr;
      int unsigned pick;
      int unsigned extra;
      int unsigned keep;
      pick = $urandom_range(0, 99);
      if (pick < 10)      op = OP_WREN;
      else if (pick < 30) op = OP_PROGRAM;
      else if (pick < 48) op = OP_READ;
      else if (pick < 58) op = OP_FAST_READ;
      else if (pick < 61) op = OP_ERASE_4K;
      else if (pick < 63) op = OP_ERASE_32K;
      else if (pick < 64) op = OP_ERASE_64K;
      else if (pick < 67) op = latch_set ? OP_WRDI :
                               (pick % 2 == 0) ? OP_CHIP_ERASE_A : OP_CHIP_ERASE_B;
      else if (pick < 70) op = OP_WRDI;
      else if (pick < 75) op = OP_RDSR1;
      else if (pick < 78) op = OP_RDSR2;
      else if (pick < 82) op = OP_JEDEC_ID;
      else if (pick < 87) op = OP_DEVICE_ID;
      else begin
         op = 8'($urandom);
         // keep whole-array erases out of the random part
         if ((op == OP_CHIP_ERASE_A || op == OP_CHIP_ERASE_B) && latch_set) op = OP_WRDI;
      end

      needs_latch = (op == OP_PROGRAM || op == OP_ERASE_4K ||
                     op == OP_ERASE_32K || op == OP_ERASE_64K);
      has_addr    = needs_latch || op == OP_READ || op == OP_FAST_READ;

      // Set the latch first in most program and erase sequences
      if (needs_latch && $urandom_range(0, 9) < 8) begin
         send_item(EVT_XFER, OP_WREN, 1'b0, '0);
         send_item(EVT_RELEASE, 8'($urandom), 1'b0, '0);
      end

      if (has_addr) begin
         a = pick_address();
         body.push_back(a[23:16]);
         body.push_back(a[15:8]);
         body.push_back(a[7:0]);
      end
      case (op)
         OP_PROGRAM:                             extra = $urandom_range(0, 12);
         OP_READ, OP_FAST_READ:                  extra = $urandom_range(1, 10);
         OP_ERASE_4K, OP_ERASE_32K, OP_ERASE_64K: extra = $urandom_range(0, 2);
         OP_RDSR1, OP_RDSR2:                     extra = $urandom_range(0, 3);
         OP_JEDEC_ID:                            extra = $urandom_range(0, 5);
         OP_DEVICE_ID:                           extra = $urandom_range(0, 8);
         OP_WREN, OP_WRDI:                       extra = $urandom_range(0, 1);
         default:                                extra = $urandom_range(0, 5);
      endcase
      repeat (extra) body.push_back(8'($urandom));

      // Cut some frames short
      keep = body.size();
      if ($urandom_range(0, 9) == 0) keep = $urandom_range(0, body.size());

      send_item(EVT_XFER, op, 1'b0, '0);
      for (int unsigned i = 0; i < keep; i++) send_item(EVT_XFER, body[i], 1'b0, '0);
      send_item(EVT_RELEASE, 8'($urandom), 1'b0, '0);
      if ($urandom_range(0, 19) == 0) send_item(EVT_RELEASE, 8'($urandom), 1'b0, '0);
   endtask

   // Stimulus
   initial begin
      foreach (image[i]) image[i] = BYTE_ERASED;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING[i])
         send_item(OPENING[i].kind, OPENING[i].data, OPENING[i].pinned, OPENING[i].reply);
      wait_for_replies();

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         no_gaps = (useful_items >= 150 && useful_items < 240);
         if ($urandom_range(0, 24) == 0) wait_for_replies();
         send_random_frame();
      end
      no_gaps = 1'b0;

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed)
         $display("spi_flash_command_slave_tb passed");
      else
         $display("spi_flash_command_slave_tb failed");
      $finish;
   end

   // Check each reply against the oldest outstanding one; stall at random outside the no-gap stretch
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: reply with none outstanding: miso_next %02h error_code %0d",
                     $time, rsp_miso_next, rsp_error_code);
            failed = 1'b1;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_miso_next !== want.miso) begin
               $display("%0t: miso_next expected %02h, actual %02h",
                        $time, want.miso, rsp_miso_next);
               failed = 1'b1;
            end
            if (rsp_error_code !== want.err) begin
               $display("%0t: error_code expected %0d, actual %0d",
                        $time, want.err, rsp_error_code);
               failed = 1'b1;
            end
         end
      end
      rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 31);
   end

   // Drop the run if nothing moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("spi_flash_command_slave_tb failed");
            $finish;
         end
      end
   end

endmodule
